// ===== src/alucb_pkg.sv =====
// Shared types and constants for the ALU, compare and branch unit.
`timescale 1ns / 1ps

package alucb_pkg;

  localparam int unsigned APB_ADDR_W = 3;

  localparam logic REG_ZERO_FLAG_BIT  = 1'b0;
  localparam logic REG_CARRY_FLAG_BIT = 1'b1;

  localparam logic [3:0] ZF_POS_RST = 4'd6;
  localparam logic [3:0] CF_POS_RST = 4'd0;

  typedef enum logic [4:0] {
    FUNC_ADD        = 5'd0,
    FUNC_SUB        = 5'd1,
    FUNC_MUL        = 5'd2,
    FUNC_DIV        = 5'd3,
    FUNC_CMP        = 5'd4,
    FUNC_AND        = 5'd5,
    FUNC_OR         = 5'd6,
    FUNC_XOR        = 5'd7,
    FUNC_NOT        = 5'd8,
    FUNC_MOV        = 5'd9,
    FUNC_JMP        = 5'd10,
    FUNC_JE         = 5'd11,
    FUNC_JNE        = 5'd12,
    FUNC_JG         = 5'd13,
    FUNC_JGE        = 5'd14,
    FUNC_JL         = 5'd15,
    FUNC_JLE        = 5'd16,
    FUNC_SETBITS    = 5'd17,
    FUNC_CLEARBITS  = 5'd18,
    FUNC_TOGGLEBITS = 5'd19
  } func_e;

  typedef struct packed {
    logic [4:0]  func;
    logic [63:0] dest_value;
    logic [63:0] src_value;
    logic [15:0] flag_mask;
  } in_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        writes_dest;
    logic        branch_taken;
    logic [63:0] next_pointer;
    logic [15:0] flags_after;
    logic        divide_error;
  } out_t;

  typedef struct packed {
    logic [3:0] zf_pos;
    logic [3:0] cf_pos;
  } cfg_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_MUL_DONE,
    ST_DIV,
    ST_DIV_DONE
  } state_e;

  typedef enum logic [1:0] {
    MUL_LL,
    MUL_LH,
    MUL_HL,
    MUL_SUM
  } mul_step_e;

  typedef enum logic [1:0] {
    SRC_ALU,
    SRC_MUL,
    SRC_DIV
  } out_src_e;

  typedef struct packed {
    logic      take;
    logic      mul_run;
    mul_step_e mul_step;
    logic      div_step;
    logic      out_load;
    out_src_e  out_src;
  } cmd_t;

  typedef struct packed {
    logic is_mul;
    logic is_div_nz;
  } stat_t;

endpackage

// ===== src/alucb_regs.sv =====
// APB configuration registers holding the zero and carry flag positions.
`timescale 1ns / 1ps

module alucb_regs (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [alucb_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  output alucb_pkg::cfg_t                    cfg_o
);

  logic [3:0] zf_pos_q, zf_pos_d;
  logic [3:0] cf_pos_q, cf_pos_d;
  logic       wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_comb begin
    zf_pos_d = zf_pos_q;
    cf_pos_d = cf_pos_q;
    prdata   = '0;
    case (paddr[2])
      alucb_pkg::REG_ZERO_FLAG_BIT: begin
        prdata = 32'(zf_pos_q);
        if (wr_en) begin
          zf_pos_d = pwdata[3:0];
        end
      end
      alucb_pkg::REG_CARRY_FLAG_BIT: begin
        prdata = 32'(cf_pos_q);
        if (wr_en) begin
          cf_pos_d = pwdata[3:0];
        end
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      zf_pos_q <= alucb_pkg::ZF_POS_RST;
      cf_pos_q <= alucb_pkg::CF_POS_RST;
    end else begin
      zf_pos_q <= zf_pos_d;
      cf_pos_q <= cf_pos_d;
    end
  end

  assign cfg_o.zf_pos = zf_pos_q;
  assign cfg_o.cf_pos = cf_pos_q;

endmodule

// ===== src/alucb_ctrl.sv =====
// Controller: handshakes, multiply step sequencing and divider iteration count.
`timescale 1ns / 1ps

module alucb_ctrl #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  input  alucb_pkg::stat_t stat_i,
  output alucb_pkg::cmd_t  cmd_o
);

  localparam int unsigned CNT_W = $clog2(DATA_WIDTH);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_WIDTH - 1);

  alucb_pkg::state_e    state_q, state_d;
  alucb_pkg::mul_step_e step_q, step_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 out_valid_q, out_valid_d;
  logic                 out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d        = state_q;
    step_d         = step_q;
    cnt_d          = cnt_q;
    in_ready_o     = 1'b0;
    cmd_o.take     = 1'b0;
    cmd_o.mul_run  = 1'b0;
    cmd_o.mul_step = step_q;
    cmd_o.div_step = 1'b0;
    cmd_o.out_load = 1'b0;
    cmd_o.out_src  = alucb_pkg::SRC_ALU;
    case (state_q)
      alucb_pkg::ST_IDLE: begin
        in_ready_o = out_free;
        if (in_valid_i && out_free) begin
          cmd_o.take = 1'b1;
          if (stat_i.is_mul) begin
            state_d = alucb_pkg::ST_MUL;
            step_d  = alucb_pkg::MUL_LL;
          end else if (stat_i.is_div_nz) begin
            state_d = alucb_pkg::ST_DIV;
            cnt_d   = '0;
          end else begin
            cmd_o.out_load = 1'b1;
            cmd_o.out_src  = alucb_pkg::SRC_ALU;
          end
        end
      end
      alucb_pkg::ST_MUL: begin
        cmd_o.mul_run = 1'b1;
        case (step_q)
          alucb_pkg::MUL_LL:  step_d = alucb_pkg::MUL_LH;
          alucb_pkg::MUL_LH:  step_d = alucb_pkg::MUL_HL;
          alucb_pkg::MUL_HL:  step_d = alucb_pkg::MUL_SUM;
          alucb_pkg::MUL_SUM: state_d = alucb_pkg::ST_MUL_DONE;
          default:            state_d = alucb_pkg::ST_MUL_DONE;
        endcase
      end
      alucb_pkg::ST_MUL_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = alucb_pkg::SRC_MUL;
          state_d        = alucb_pkg::ST_IDLE;
        end
      end
      alucb_pkg::ST_DIV: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = alucb_pkg::ST_DIV_DONE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      alucb_pkg::ST_DIV_DONE: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          cmd_o.out_src  = alucb_pkg::SRC_DIV;
          state_d        = alucb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = alucb_pkg::ST_IDLE;
      end
    endcase
    out_valid_d = cmd_o.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= alucb_pkg::ST_IDLE;
      step_q      <= alucb_pkg::MUL_LL;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== src/alucb_datapath.sv =====
// Datapath: ALU, flags and pointer state, shared multiplier, divider.
`timescale 1ns / 1ps

module alucb_datapath #(
  parameter int unsigned DATA_WIDTH = 64,
  parameter int unsigned FLAG_WIDTH = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  alucb_pkg::in_t   in_i,
  input  alucb_pkg::cfg_t  cfg_i,
  input  alucb_pkg::cmd_t  cmd_i,
  output alucb_pkg::stat_t stat_o,
  output alucb_pkg::out_t  out_o
);

  localparam int unsigned HALF = (DATA_WIDTH + 1) / 2;
  localparam int unsigned HIGH = DATA_WIDTH - HALF;

  logic [DATA_WIDTH-1:0] d_w, s_w;
  logic [FLAG_WIDTH-1:0] m_w;
  logic [15:0]           zf_hot, cf_hot;
  logic [FLAG_WIDTH-1:0] zf_m, cf_m;
  logic                  z, c;

  logic [FLAG_WIDTH-1:0] flags_q, flags_d;
  logic [DATA_WIDTH-1:0] ip_q, ip_d;

  logic [DATA_WIDTH-1:0] res;
  logic                  wr, jump, cond, derr, taken;

  logic [DATA_WIDTH-1:0] op_a_q, op_b_q;
  logic [HALF-1:0]       mul_a, mul_b;
  logic [2*HALF-1:0]     prod_q;
  logic [DATA_WIDTH-1:0] prod_sh;
  logic [DATA_WIDTH-1:0] acc_q;

  logic [DATA_WIDTH-1:0] quo_q;
  logic [DATA_WIDTH:0]   rem_q, rem_sh, rem_diff;

  alucb_pkg::out_t out_q;

  assign d_w = in_i.dest_value[DATA_WIDTH-1:0];
  assign s_w = in_i.src_value[DATA_WIDTH-1:0];
  assign m_w = in_i.flag_mask[FLAG_WIDTH-1:0];

  assign zf_hot = 16'd1 << cfg_i.zf_pos;
  assign cf_hot = 16'd1 << cfg_i.cf_pos;
  assign zf_m   = zf_hot[FLAG_WIDTH-1:0];
  assign cf_m   = cf_hot[FLAG_WIDTH-1:0];
  assign z      = |(flags_q & zf_m);
  assign c      = |(flags_q & cf_m);

  assign stat_o.is_mul    = (in_i.func == alucb_pkg::FUNC_MUL);
  assign stat_o.is_div_nz = (in_i.func == alucb_pkg::FUNC_DIV) && (s_w != '0);

  always_comb begin
    res     = '0;
    wr      = 1'b0;
    jump    = 1'b0;
    cond    = 1'b0;
    derr    = 1'b0;
    flags_d = flags_q;
    case (in_i.func)
      alucb_pkg::FUNC_ADD: begin res = d_w + s_w; wr = 1'b1; end
      alucb_pkg::FUNC_SUB: begin res = d_w - s_w; wr = 1'b1; end
      alucb_pkg::FUNC_MUL: wr = 1'b1;
      alucb_pkg::FUNC_DIV: begin
        // only reaches the output here for a zero divisor
        res  = '1;
        wr   = 1'b1;
        derr = (s_w == '0);
      end
      alucb_pkg::FUNC_CMP: begin
        if (d_w == s_w) begin
          flags_d = (flags_q | zf_m) & ~cf_m;
        end else if (d_w < s_w) begin
          flags_d = (flags_q & ~zf_m) | cf_m;
        end else begin
          flags_d = flags_q & ~zf_m & ~cf_m;
        end
      end
      alucb_pkg::FUNC_AND: begin res = d_w & s_w; wr = 1'b1; end
      alucb_pkg::FUNC_OR:  begin res = d_w | s_w; wr = 1'b1; end
      alucb_pkg::FUNC_XOR: begin res = d_w ^ s_w; wr = 1'b1; end
      alucb_pkg::FUNC_NOT: begin res = ~d_w;      wr = 1'b1; end
      alucb_pkg::FUNC_MOV: begin res = s_w;       wr = 1'b1; end
      alucb_pkg::FUNC_JMP: begin jump = 1'b1; cond = 1'b1;     end
      alucb_pkg::FUNC_JE:  begin jump = 1'b1; cond = z && !c;  end
      alucb_pkg::FUNC_JNE: begin jump = 1'b1; cond = !z;       end
      alucb_pkg::FUNC_JG:  begin jump = 1'b1; cond = !z && !c; end
      alucb_pkg::FUNC_JGE: begin jump = 1'b1; cond = !c;       end
      alucb_pkg::FUNC_JL:  begin jump = 1'b1; cond = c && !z;  end
      alucb_pkg::FUNC_JLE: begin jump = 1'b1; cond = z || c;   end
      alucb_pkg::FUNC_SETBITS:    flags_d = flags_q | m_w;
      alucb_pkg::FUNC_CLEARBITS:  flags_d = flags_q & ~m_w;
      alucb_pkg::FUNC_TOGGLEBITS: flags_d = flags_q ^ m_w;
      default: begin
        res = '0;
      end
    endcase
    taken = jump && cond;
    ip_d  = taken ? d_w : ip_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flags_q <= '0;
      ip_q    <= '0;
    end else if (cmd_i.take) begin
      flags_q <= flags_d;
      ip_q    <= ip_d;
    end
  end

  // low half product from three half-width partial products
  always_comb begin
    mul_a = op_a_q[HALF-1:0];
    mul_b = op_b_q[HALF-1:0];
    case (cmd_i.mul_step)
      alucb_pkg::MUL_LH: mul_b = HALF'(op_b_q[DATA_WIDTH-1:HALF]);
      alucb_pkg::MUL_HL: mul_a = HALF'(op_a_q[DATA_WIDTH-1:HALF]);
      default: begin
        mul_a = op_a_q[HALF-1:0];
      end
    endcase
  end

  assign prod_sh = {prod_q[HIGH-1:0], {HALF{1'b0}}};

  assign rem_sh   = {rem_q[DATA_WIDTH-1:0], quo_q[DATA_WIDTH-1]};
  assign rem_diff = rem_sh - {1'b0, op_b_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_a_q <= d_w;
      op_b_q <= s_w;
      quo_q  <= d_w;
      rem_q  <= '0;
    end else if (cmd_i.div_step) begin
      if (!rem_diff[DATA_WIDTH]) begin
        rem_q <= rem_diff;
        quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b1};
      end else begin
        rem_q <= rem_sh;
        quo_q <= {quo_q[DATA_WIDTH-2:0], 1'b0};
      end
    end
    if (cmd_i.mul_run) begin
      prod_q <= mul_a * mul_b;
      case (cmd_i.mul_step)
        alucb_pkg::MUL_LH:  acc_q <= prod_q[DATA_WIDTH-1:0];
        alucb_pkg::MUL_HL:  acc_q <= acc_q + prod_sh;
        alucb_pkg::MUL_SUM: acc_q <= acc_q + prod_sh;
        default:            acc_q <= acc_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      case (cmd_i.out_src)
        alucb_pkg::SRC_MUL: begin
          out_q.result_value <= 64'(acc_q);
          out_q.writes_dest  <= 1'b1;
          out_q.branch_taken <= 1'b0;
          out_q.next_pointer <= 64'(ip_q);
          out_q.flags_after  <= 16'(flags_q);
          out_q.divide_error <= 1'b0;
        end
        alucb_pkg::SRC_DIV: begin
          out_q.result_value <= 64'(quo_q);
          out_q.writes_dest  <= 1'b1;
          out_q.branch_taken <= 1'b0;
          out_q.next_pointer <= 64'(ip_q);
          out_q.flags_after  <= 16'(flags_q);
          out_q.divide_error <= 1'b0;
        end
        default: begin
          out_q.result_value <= 64'(res);
          out_q.writes_dest  <= wr;
          out_q.branch_taken <= taken;
          out_q.next_pointer <= 64'(ip_d);
          out_q.flags_after  <= 16'(flags_d);
          out_q.divide_error <= derr;
        end
      endcase
    end
  end

  assign out_o = out_q;

endmodule

// ===== src/alu_compare_branch_unit.sv =====
// Top level of the ALU, compare and branch unit.
`timescale 1ns / 1ps

// 64-bit ALU with a flags word and an instruction pointer. Add, subtract,
// logic, move, compare, jumps, flag operations and a divide with a zero
// divisor load the result register in the cycle they are taken, so a new
// item is taken every cycle while the result register drains. Multiply:
// one half-width multiplier builds the low half from three partial products
// over four steps. Divide: the restoring divider retires one quotient bit
// per cycle. The input stalls until their result loads. Flag positions are
// set through the APB port: zero flag bit at 0x0, carry flag bit at 0x4.
module alu_compare_branch_unit #(
  parameter int unsigned DATA_WIDTH = 64,
  parameter int unsigned FLAG_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  alucb_pkg::in_t                   in_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output alucb_pkg::out_t                  out_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [alucb_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready
);

  alucb_pkg::cfg_t  cfg;
  alucb_pkg::cmd_t  cmd;
  alucb_pkg::stat_t stat;

  alucb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  alucb_ctrl #(
    .DATA_WIDTH (DATA_WIDTH)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  alucb_datapath #(
    .DATA_WIDTH (DATA_WIDTH),
    .FLAG_WIDTH (FLAG_WIDTH)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .cfg_i  (cfg),
    .cmd_i  (cmd),
    .stat_o (stat),
    .out_o  (out_o)
  );

  a_mul_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_i.func == alucb_pkg::FUNC_MUL) |=> !in_ready_o)
    else $error("input taken while multiply in progress");

  a_single_cycle_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && (in_i.func != alucb_pkg::FUNC_MUL) &&
    !((in_i.func == alucb_pkg::FUNC_DIV) && (in_i.src_value[DATA_WIDTH-1:0] != '0))
    |=> out_valid_o)
    else $error("single-cycle op gave no result in the next cycle");

  a_div_error_writes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.divide_error |-> out_o.writes_dest && !out_o.branch_taken)
    else $error("divide error without write-back");

  a_branch_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_o.branch_taken |-> !out_o.writes_dest && (out_o.result_value == '0))
    else $error("taken branch also writes a result");

endmodule
